FILE: hw/rtl/tlpt_pkg.sv
// tlpt_pkg: constants, codes and types of the two-level page table manager
// no dependencies; compiled first
`timescale 1ns / 1ps

package tlpt_pkg;

    // table geometry
    localparam int TABLE_SLOTS       = 16;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int PAGE_BYTES        = 4096;
    localparam int DIR_ENTRIES       = 1024;

    // derived widths
    localparam int OFS_W   = $clog2(PAGE_BYTES);
    localparam int DIR_AW  = $clog2(DIR_ENTRIES);
    localparam int ENT_AW  = $clog2(ENTRIES_PER_TABLE);
    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NFS_W   = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W   = SLOT_W + 1;
    localparam int PG_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int PG_AW   = $clog2(PG_DEPTH);
    localparam int CNT_W   = DIR_AW;

    // payload widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int FLAGS_W = 12;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNALIGNED = 3'd1,
        STAT_NO_SLOT   = 3'd2,
        STAT_MAPPED    = 3'd3,
        STAT_NO_TABLE  = 3'd4,
        STAT_NO_PAGE   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIR_RD,
        ST_CLEAR,
        ST_PG_REQ,
        ST_PG_RD,
        ST_RESP
    } t_state;

endpackage

FILE: hw/rtl/tlpt_cmd_if.sv
// tlpt_cmd_if: command request channel of the page table manager
// depends on tlpt_pkg for the payload widths
`timescale 1ns / 1ps

interface tlpt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tlpt_pkg::CMD_W-1:0]    command;
    logic [tlpt_pkg::ADDR_W-1:0]   virt_addr;
    logic [tlpt_pkg::ADDR_W-1:0]   phys_addr;
    logic [tlpt_pkg::FLAGS_W-1:0]  page_flags;
    logic [tlpt_pkg::COUNT_W-1:0]  page_count;

    modport source (output valid, command, virt_addr, phys_addr, page_flags, page_count,
                    input ready);
    modport sink   (input valid, command, virt_addr, phys_addr, page_flags, page_count,
                    output ready);
endinterface

FILE: hw/rtl/tlpt_res_if.sv
// tlpt_res_if: result request channel of the page table manager
// depends on tlpt_pkg for the payload widths
`timescale 1ns / 1ps

interface tlpt_res_if;
    logic                         valid;
    logic                         ready;
    logic [tlpt_pkg::STAT_W-1:0]  status;
    logic [tlpt_pkg::ADDR_W-1:0]  frame_addr;
    logic [tlpt_pkg::ADDR_W-1:0]  fail_addr;

    modport source (output valid, status, frame_addr, fail_addr, input ready);
    modport sink   (input valid, status, frame_addr, fail_addr, output ready);
endinterface

FILE: hw/rtl/two_level_page_table_manager.sv
// two_level_page_table_manager: directory memory, page entry memory and sequencer
// depends on tlpt_pkg, tlpt_cmd_if and tlpt_res_if
`timescale 1ns / 1ps

// Usage
//   i_cmd carries one request: map, unmap run or translate, with its addresses,
//   flags and page count. o_res returns exactly one result per request: status,
//   translated frame and the address where an unmap run stopped.
//   Requests are handled one at a time; i_cmd.ready is high only while the
//   sequencer is idle. The directory and the page entries sit in two
//   synchronous memories with a registered read. Map and translate walk
//   directory read then page entry read before the response step; an
//   unaligned request, an unknown command or an unmap with a zero count goes
//   straight to the response step, a refusal at the directory after the
//   directory read. Each further page of an unmap run adds a directory read
//   and an entry read. A map that takes a new table slot adds a clear sweep,
//   one entry per cycle through the page entry write port, and a re-read of
//   the entry. After reset the directory is swept to "not present" while
//   i_cmd.ready stays low. The result sits in an output register; if the
//   receiver stalls, the result holds and the sequencer waits in its response
//   step until the register frees, and no further request is accepted.

module two_level_page_table_manager (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlpt_cmd_if.sink   i_cmd,
    tlpt_res_if.source o_res
);
    import tlpt_pkg::*;

    // memories
    logic [DIR_W-1:0]  dir_mem [DIR_ENTRIES];
    logic [ADDR_W-1:0] pg_mem  [PG_DEPTH];

    // registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_cmd               r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_va, n_va;
    logic [ADDR_W-1:0]  r_pa, n_pa;
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [NFS_W-1:0]   r_next_free, n_next_free;
    t_status            r_res_status, n_res_status;
    logic [ADDR_W-1:0]  r_res_frame, n_res_frame;
    logic [ADDR_W-1:0]  r_res_fail, n_res_fail;
    logic               r_out_valid, n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [ADDR_W-1:0]  r_out_frame, n_out_frame;
    logic [ADDR_W-1:0]  r_out_fail, n_out_fail;
    logic [DIR_W-1:0]   r_dir_q;
    logic [ADDR_W-1:0]  r_pg_q;

    // memory access controls
    logic              dir_we, dir_re;
    logic [DIR_AW-1:0] dir_waddr, dir_raddr;
    logic [DIR_W-1:0]  dir_wdata;
    logic              pg_we, pg_re;
    logic [PG_AW-1:0]  pg_waddr, pg_raddr;
    logic [ADDR_W-1:0] pg_wdata;

    // decoded read data
    logic              dir_present;
    logic [SLOT_W-1:0] dir_slot;
    logic [ENT_AW-1:0] ent_idx;
    logic [ADDR_W-1:0] va_next;

    assign dir_present = r_dir_q[DIR_W-1];
    assign dir_slot    = r_dir_q[SLOT_W-1:0];
    assign ent_idx     = r_va[OFS_W +: ENT_AW];
    assign va_next     = r_va + ADDR_W'(PAGE_BYTES);

    // directory memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_q <= dir_mem[dir_raddr];
        end
    end

    // page entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            pg_mem[pg_waddr] <= pg_wdata;
        end
        if (pg_re) begin
            r_pg_q <= pg_mem[pg_raddr];
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_va         <= n_va;
        r_pa         <= n_pa;
        r_flags      <= n_flags;
        r_count      <= n_count;
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_res_fail   <= n_res_fail;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
        r_out_fail   <= n_out_fail;
    end

    // sequencer: next state, memory accesses and result
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_va         = r_va;
        n_pa         = r_pa;
        n_flags      = r_flags;
        n_count      = r_count;
        n_slot       = r_slot;
        n_next_free  = r_next_free;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        n_res_fail   = r_res_fail;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_frame  = r_out_frame;
        n_out_fail   = r_out_fail;
        dir_we       = 1'b0;
        dir_waddr    = r_va[OFS_W + ENT_AW +: DIR_AW];
        dir_wdata    = '0;
        dir_re       = 1'b0;
        dir_raddr    = r_va[OFS_W + ENT_AW +: DIR_AW];
        pg_we        = 1'b0;
        pg_waddr     = PG_AW'({r_slot, ent_idx});
        pg_wdata     = '0;
        pg_re        = 1'b0;
        pg_raddr     = PG_AW'({r_slot, ent_idx});
        i_cmd.ready  = 1'b0;

        unique case (r_state)
            // directory sweep to not present after reset
            ST_INIT: begin
                dir_we    = 1'b1;
                dir_waddr = r_cnt;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIR_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // take a request and start the directory read
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd        = t_cmd'(i_cmd.command);
                    n_va         = i_cmd.virt_addr;
                    n_pa         = i_cmd.phys_addr;
                    n_flags      = i_cmd.page_flags;
                    n_count      = i_cmd.page_count;
                    n_res_status = STAT_OK;
                    n_res_frame  = '0;
                    n_res_fail   = '0;
                    dir_raddr    = i_cmd.virt_addr[OFS_W + ENT_AW +: DIR_AW];
                    unique case (i_cmd.command)
                        CMD_MAP: begin
                            if (i_cmd.virt_addr[OFS_W-1:0] != '0 ||
                                i_cmd.phys_addr[OFS_W-1:0] != '0) begin
                                n_res_status = STAT_UNALIGNED;
                                n_state      = ST_RESP;
                            end else begin
                                dir_re  = 1'b1;
                                n_state = ST_DIR_RD;
                            end
                        end
                        CMD_UNMAP: begin
                            if (i_cmd.virt_addr[OFS_W-1:0] != '0) begin
                                n_res_status = STAT_UNALIGNED;
                                n_state      = ST_RESP;
                            end else if (i_cmd.page_count == '0) begin
                                n_state = ST_RESP;
                            end else begin
                                dir_re  = 1'b1;
                                n_state = ST_DIR_RD;
                            end
                        end
                        CMD_XLATE: begin
                            if (i_cmd.virt_addr[OFS_W-1:0] != '0) begin
                                n_res_status = STAT_UNALIGNED;
                                n_state      = ST_RESP;
                            end else begin
                                dir_re  = 1'b1;
                                n_state = ST_DIR_RD;
                            end
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            // directory entry is back: allocate, fail or read the page entry
            ST_DIR_RD: begin
                if (!dir_present) begin
                    if (r_cmd == CMD_MAP) begin
                        if (r_next_free >= NFS_W'(TABLE_SLOTS)) begin
                            n_res_status = STAT_NO_SLOT;
                            n_state      = ST_RESP;
                        end else begin
                            dir_we      = 1'b1;
                            dir_wdata   = {1'b1, SLOT_W'(r_next_free)};
                            n_slot      = SLOT_W'(r_next_free);
                            n_next_free = r_next_free + 1'b1;
                            n_cnt       = '0;
                            n_state     = ST_CLEAR;
                        end
                    end else begin
                        n_res_status = STAT_NO_TABLE;
                        if (r_cmd == CMD_UNMAP) begin
                            n_res_fail = r_va;
                        end
                        n_state = ST_RESP;
                    end
                end else begin
                    n_slot   = dir_slot;
                    pg_re    = 1'b1;
                    pg_raddr = PG_AW'({dir_slot, ent_idx});
                    n_state  = ST_PG_RD;
                end
            end

            // zero every entry of a freshly taken slot
            ST_CLEAR: begin
                pg_we    = 1'b1;
                pg_waddr = PG_AW'({r_slot, r_cnt});
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ENTRIES_PER_TABLE - 1)) begin
                    n_state = ST_PG_REQ;
                end
            end

            // page entry read once the clear is done
            ST_PG_REQ: begin
                pg_re   = 1'b1;
                n_state = ST_PG_RD;
            end

            // page entry is back: update or report
            ST_PG_RD: begin
                unique case (r_cmd)
                    CMD_MAP: begin
                        if (r_pg_q[0]) begin
                            n_res_status = STAT_MAPPED;
                        end else begin
                            pg_we    = 1'b1;
                            pg_wdata = {r_pa[ADDR_W-1:OFS_W], r_flags};
                        end
                        n_state = ST_RESP;
                    end
                    CMD_XLATE: begin
                        if (!r_pg_q[0]) begin
                            n_res_status = STAT_NO_PAGE;
                        end else begin
                            n_res_frame = {r_pg_q[ADDR_W-1:OFS_W], OFS_W'(0)};
                        end
                        n_state = ST_RESP;
                    end
                    CMD_UNMAP: begin
                        if (!r_pg_q[0]) begin
                            n_res_status = STAT_NO_PAGE;
                            n_res_fail   = r_va;
                            n_state      = ST_RESP;
                        end else begin
                            pg_we   = 1'b1;
                            n_va    = va_next;
                            n_count = r_count - 1'b1;
                            if (r_count == COUNT_W'(1)) begin
                                n_state = ST_RESP;
                            end else begin
                                dir_re    = 1'b1;
                                dir_raddr = va_next[OFS_W + ENT_AW +: DIR_AW];
                                n_state   = ST_DIR_RD;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end

            // move the result into the output register when it is free
            ST_RESP: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_frame  = r_res_frame;
                    n_out_fail   = r_res_fail;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // result channel
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.frame_addr = r_out_frame;
    assign o_res.fail_addr  = r_out_fail;

    // slot pool never runs past its size
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NFS_W'(TABLE_SLOTS))
        else $error("slot pool count out of range");

    // a directory entry is made present only while a slot is still free
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dir_we && dir_wdata[DIR_W-1]) |-> (r_next_free < NFS_W'(TABLE_SLOTS)))
        else $error("directory entry allocated from an empty pool");

    // one request at a time: acceptance drops ready in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("request accepted while another is in flight");

    // a returned frame is always page aligned
    a_frame_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.frame_addr[OFS_W-1:0] == '0))
        else $error("frame address not page aligned");

endmodule

FILE: sim/testbench.sv
// testbench: self-checking regression of two_level_page_table_manager
// depends on tlpt_pkg, tlpt_cmd_if, tlpt_res_if and the manager itself
// a local page table copy predicts each result; a checker compares them in order
`timescale 1ns / 1ps

module testbench;
    import tlpt_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 680;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_BUDGET = 20;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    typedef struct {
        t_status              status;
        logic [ADDR_W-1:0]    frame_addr;
        logic [ADDR_W-1:0]    fail_addr;
    } t_table_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlpt_cmd_if cmd_bus ();
    tlpt_res_if res_bus ();

    two_level_page_table_manager dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // shadow page table
    logic              dir_valid   [DIR_ENTRIES];
    logic [SLOT_W-1:0] dir_slot_of [DIR_ENTRIES];
    logic [ADDR_W-1:0] entry_mem   [PG_DEPTH];
    int unsigned       slots_taken;

    t_table_result pending_results [$];

    bit          gaps_on = 1'b1;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned count_map, count_unmap, count_xlate, count_other;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_BUDGET)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    function automatic logic [ADDR_W-1:0] page_va(input logic [DIR_AW-1:0] dir,
                                                  input int unsigned ent);
        return {dir, ent[ENT_AW-1:0], {OFS_W{1'b0}}};
    endfunction

    function automatic logic [ADDR_W-1:0] rand_frame();
        logic [ADDR_W-1:0] w = $urandom;
        return {w[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
    endfunction

    // mostly present pages, sometimes an entry written without the present bit
    function automatic logic [FLAGS_W-1:0] rand_flags();
        logic [FLAGS_W-1:0] f = FLAGS_W'($urandom);
        f[0] = ($urandom_range(9) != 0);
        return f;
    endfunction

    function automatic int unsigned pick_entry();
        int unsigned sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(15);
        if (sel < 80)
            return $urandom_range(1023, 1008);
        return $urandom_range(1023);
    endfunction

    function automatic int unsigned entry_ptr(input logic [DIR_AW-1:0] d,
                                              input logic [ADDR_W-1:0] va);
        return int'(dir_slot_of[d]) * ENTRIES_PER_TABLE + int'(va[OFS_W+ENT_AW-1:OFS_W]);
    endfunction

    // apply one accepted request to the shadow table and queue its result
    task automatic predict_table_result(input logic [CMD_W-1:0] cmd,
                                        input logic [ADDR_W-1:0] va_in,
                                        input logic [ADDR_W-1:0] pa,
                                        input logic [FLAGS_W-1:0] flags,
                                        input logic [COUNT_W-1:0] count);
        t_table_result     res;
        logic [ADDR_W-1:0] va;
        logic [DIR_AW-1:0] d;
        int unsigned       slot_base;
        int unsigned       n;
        res.status     = STAT_OK;
        res.frame_addr = '0;
        res.fail_addr  = '0;
        va = va_in;
        d  = va[ADDR_W-1:ADDR_W-DIR_AW];
        case (cmd)
            CMD_MAP: begin
                count_map++;
                if (va[OFS_W-1:0] != 0 || pa[OFS_W-1:0] != 0) begin
                    res.status = STAT_UNALIGNED;
                end else if (!dir_valid[d] && slots_taken >= TABLE_SLOTS) begin
                    res.status = STAT_NO_SLOT;
                end else begin
                    // new region takes the next slot, cleared
                    if (!dir_valid[d]) begin
                        dir_valid[d]   = 1'b1;
                        dir_slot_of[d] = SLOT_W'(slots_taken);
                        slot_base      = slots_taken * ENTRIES_PER_TABLE;
                        for (n = 0; n < ENTRIES_PER_TABLE; n++)
                            entry_mem[slot_base + n] = '0;
                        slots_taken++;
                    end
                    if (entry_mem[entry_ptr(d, va)][0])
                        res.status = STAT_MAPPED;
                    else
                        entry_mem[entry_ptr(d, va)] = {pa[ADDR_W-1:OFS_W], flags};
                end
            end
            CMD_UNMAP: begin
                count_unmap++;
                // walk the run, address wraps at the top
                if (va[OFS_W-1:0] != 0) begin
                    res.status = STAT_UNALIGNED;
                end else begin
                    for (n = 0; n < count; n++) begin
                        d = va[ADDR_W-1:ADDR_W-DIR_AW];
                        if (!dir_valid[d]) begin
                            res.status    = STAT_NO_TABLE;
                            res.fail_addr = va;
                            break;
                        end
                        if (!entry_mem[entry_ptr(d, va)][0]) begin
                            res.status    = STAT_NO_PAGE;
                            res.fail_addr = va;
                            break;
                        end
                        entry_mem[entry_ptr(d, va)] = '0;
                        va += PAGE_BYTES;
                    end
                end
            end
            CMD_XLATE: begin
                count_xlate++;
                if (va[OFS_W-1:0] != 0)
                    res.status = STAT_UNALIGNED;
                else if (!dir_valid[d])
                    res.status = STAT_NO_TABLE;
                else if (!entry_mem[entry_ptr(d, va)][0])
                    res.status = STAT_NO_PAGE;
                else
                    res.frame_addr = {entry_mem[entry_ptr(d, va)][ADDR_W-1:OFS_W],
                                      {OFS_W{1'b0}}};
            end
            default: begin
                count_other++;
            end
        endcase
        pending_results.push_back(res);
    endtask

    // drive one request, with random idle cycles ahead of it
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ADDR_W-1:0] va,
                                input logic [ADDR_W-1:0] pa,
                                input logic [FLAGS_W-1:0] flags,
                                input logic [COUNT_W-1:0] count);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 15) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= cmd;
        cmd_bus.virt_addr  <= va;
        cmd_bus.phys_addr  <= pa;
        cmd_bus.page_flags <= flags;
        cmd_bus.page_count <= count;
        @(posedge i_clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge i_clk);
        predict_table_result(cmd, va, pa, flags, count);
        if (cmd != CMD_UNDEF)
            items_sent++;
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        res_bus.ready <= gaps_on ? ($urandom_range(99) >= 15) : 1'b1;
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_table_result want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", ADDR_W'(res_bus.status), '0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (res_bus.status !== want.status)
                    report_mismatch("status", ADDR_W'(res_bus.status), ADDR_W'(want.status));
                if (res_bus.frame_addr !== want.frame_addr)
                    report_mismatch("frame_addr", res_bus.frame_addr, want.frame_addr);
                if (res_bus.fail_addr !== want.fail_addr)
                    report_mismatch("fail_addr", res_bus.fail_addr, want.fail_addr);
            end
        end
    end

    // nothing mapped yet
    task automatic test_reset_state();
        send_request(CMD_XLATE, 32'h0000_0000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
        send_request(CMD_UNMAP, 32'h0040_0000, $urandom, FLAGS_W'($urandom), 11'd5);
    endtask

    // misaligned virtual or frame address
    task automatic test_alignment();
        send_request(CMD_MAP, 32'h0000_0FFF, 32'h0000_0000, 12'h001, COUNT_W'($urandom));
        send_request(CMD_MAP, 32'h0000_0000, 32'h0000_0001, 12'h001, COUNT_W'($urandom));
        send_request(CMD_UNMAP, 32'h0000_0800, $urandom, FLAGS_W'($urandom), 11'd1);
        send_request(CMD_XLATE, 32'hFFFF_FFFF, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
    endtask

    // map and translate at the address extremes, double map, entries without present bit
    task automatic test_map_translate();
        send_request(CMD_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 12'hFFF, 11'h7FF);
        send_request(CMD_MAP, 32'h0000_0000, 32'h0000_0000, 12'h001, 11'h000);
        send_request(CMD_MAP, 32'h0000_0000, rand_frame(), 12'h001, COUNT_W'($urandom));
        send_request(CMD_XLATE, 32'hFFFF_F000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
        send_request(CMD_XLATE, 32'h003F_F000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
        send_request(CMD_MAP, 32'h0000_5000, 32'h1234_5000, 12'hFFE, COUNT_W'($urandom));
        send_request(CMD_XLATE, 32'h0000_5000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
        send_request(CMD_MAP, 32'h0000_5000, 32'hABCD_E000, 12'h001, COUNT_W'($urandom));
        send_request(CMD_XLATE, 32'h0000_5000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
    endtask

    // zero count, wrap at the top, partial runs, runs into an absent table
    task automatic test_unmap_runs();
        send_request(CMD_UNMAP, 32'h0000_5000, $urandom, FLAGS_W'($urandom), 11'd0);
        send_request(CMD_UNMAP, 32'hFFFF_F000, $urandom, FLAGS_W'($urandom), 11'd1024);
        send_request(CMD_XLATE, 32'h0000_0000, $urandom, FLAGS_W'($urandom),
                     COUNT_W'($urandom));
        send_request(CMD_UNMAP, 32'h0000_5000, $urandom, FLAGS_W'($urandom), 11'h7FF);
        send_request(CMD_MAP, 32'h003F_F000, rand_frame(), 12'h801, COUNT_W'($urandom));
        send_request(CMD_UNMAP, 32'h003F_F000, $urandom, FLAGS_W'($urandom), 11'd2);
    endtask

    task automatic test_unknown_command();
        send_request(CMD_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 11'h7FF);
    endtask

    // map bursts with translates and unmap runs over a few hot regions, plus noise
    task automatic test_random_traffic();
        logic [DIR_AW-1:0] hot_dir [12];
        logic [ADDR_W-1:0] va0;
        int unsigned       first, done, pick, n, k;
        hot_dir[0] = 10'd0;
        hot_dir[1] = 10'd1;
        hot_dir[2] = 10'd1023;
        hot_dir[3] = 10'd511;
        hot_dir[4] = 10'd512;
        for (k = 5; k < 12; k++)
            hot_dir[k] = DIR_AW'($urandom_range(1023));
        first = items_sent;
        done  = 0;
        while (done < RANDOM_ITEMS) begin
            // a long stretch with both sides streaming
            gaps_on = !(done >= 250 && done < 400);
            pick = $urandom_range(99);
            va0  = page_va(hot_dir[$urandom_range(11)], pick_entry());
            if (pick < 45) begin
                n = $urandom_range(8, 1);
                for (k = 0; k < n; k++)
                    send_request(CMD_MAP, va0 + k * PAGE_BYTES, rand_frame(), rand_flags(),
                                 COUNT_W'($urandom));
                for (k = 0; k < n; k++)
                    if ($urandom_range(1))
                        send_request(CMD_XLATE, va0 + k * PAGE_BYTES, $urandom,
                                     FLAGS_W'($urandom), COUNT_W'($urandom));
                if ($urandom_range(99) < 60)
                    send_request(CMD_UNMAP, va0, $urandom, FLAGS_W'($urandom),
                                 COUNT_W'(n + $urandom_range(2)));
            end else if (pick < 65) begin
                send_request(CMD_XLATE, va0, $urandom, FLAGS_W'($urandom),
                             COUNT_W'($urandom));
            end else if (pick < 80) begin
                k = $urandom_range(99);
                n = (k < 70) ? $urandom_range(8) :
                    (k < 90) ? $urandom_range(64, 9) : $urandom_range(2047);
                send_request(CMD_UNMAP, va0, $urandom, FLAGS_W'($urandom), COUNT_W'(n));
            end else begin
                case ($urandom_range(4))
                    0: send_request(CMD_UNDEF, $urandom, $urandom, FLAGS_W'($urandom),
                                    COUNT_W'($urandom));
                    1: send_request(CMD_W'($urandom_range(2)), $urandom, $urandom,
                                    FLAGS_W'($urandom), COUNT_W'($urandom));
                    2: send_request(CMD_W'($urandom_range(2)), va0 | $urandom_range(4095, 1),
                                    rand_frame(), rand_flags(), COUNT_W'($urandom_range(8)));
                    3: send_request(CMD_MAP, va0, rand_frame() | $urandom_range(4095, 1),
                                    rand_flags(), COUNT_W'($urandom));
                    default: send_request(CMD_MAP,
                                          page_va(DIR_AW'($urandom_range(1023)),
                                                  $urandom_range(1023)),
                                          rand_frame(), rand_flags(), COUNT_W'($urandom));
                endcase
            end
            done = items_sent - first;
        end
        gaps_on = 1'b1;
    endtask

    // fresh regions until the slot pool refuses twice
    task automatic test_pool_exhaustion();
        logic [DIR_AW-1:0] d;
        logic [ADDR_W-1:0] va;
        int unsigned       refused;
        refused = 0;
        while (refused < 2) begin
            d = DIR_AW'($urandom_range(1023));
            if (!dir_valid[d]) begin
                if (slots_taken >= TABLE_SLOTS)
                    refused++;
                va = page_va(d, $urandom_range(1023));
                send_request(CMD_MAP, va, rand_frame(), rand_flags(), COUNT_W'($urandom));
                if (refused == 2)
                    send_request(CMD_XLATE, va, $urandom, FLAGS_W'($urandom),
                                 COUNT_W'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            dir_valid[i]   = 1'b0;
            dir_slot_of[i] = '0;
        end
        for (int i = 0; i < PG_DEPTH; i++)
            entry_mem[i] = '0;
        slots_taken        = 0;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.command    = CMD_MAP;
        cmd_bus.virt_addr  = '0;
        cmd_bus.phys_addr  = '0;
        cmd_bus.page_flags = '0;
        cmd_bus.page_count = '0;
        res_bus.ready      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_alignment();
        test_map_translate();
        test_unmap_runs();
        test_unknown_command();
        test_random_traffic();
        test_pool_exhaustion();

        // drain outstanding results
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d map, %0d unmap, %0d translate, %0d unknown requests; %0d results checked",
                 count_map, count_unmap, count_xlate, count_other, results_checked);
        $display("table slots in use %0d of %0d, %0d mismatches, %0d cycles",
                 slots_taken, TABLE_SLOTS, error_count, cycle_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
